@@ rtl/ttm_pkg.sv @@
// Shared types, constants and the logarithm table of the thermistor temperature block.
package ttm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 16;
  localparam int SER_W      = 20;
  localparam int LIM_W      = 22;
  localparam int CORR_W     = 11;
  localparam int TEMP_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORR   = 2'd2;

  localparam int LN_W  = 21;
  localparam int LQ_W  = 21;
  localparam int L2_W  = 26;
  localparam int L3_W  = 31;
  localparam int T1_W  = 33;
  localparam int DIV_W = 54;
  localparam int DVS_W = 35;
  localparam int D_W   = 36;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [28:0] COEF_A   = 29'd416822000;
  localparam logic [27:0] COEF_B   = 28'd262234000;
  localparam logic [22:0] COEF_C   = 23'd6726371;
  localparam logic [15:0] LN2_Q16  = 16'd45426;
  localparam logic [DIV_W-1:0] ONE_E14 = 54'd100000000000000;
  localparam logic signed [19:0] KELVIN_OFS = 20'sd27315;

  // Division by 25 of values below 2^21 as a multiply by ceil(2^26/25) and a shift.
  localparam logic [21:0] RCP25  = 22'd2684355;
  localparam logic [4:0]  DIV25  = 5'd25;
  localparam int          RCP_SH = 26;

  localparam logic signed [TEMP_W-1:0] TEMP_MISSING = -17'sd40000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 17'sd30000;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -17'sd10000;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
  localparam logic [OP_W-1:0] OP_ACC   = 5'd1;
  localparam logic [OP_W-1:0] OP_TRIM  = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 5'd3;
  localparam logic [OP_W-1:0] OP_NORM  = 5'd4;
  localparam logic [OP_W-1:0] OP_LN    = 5'd5;
  localparam logic [OP_W-1:0] OP_LQ    = 5'd6;
  localparam logic [OP_W-1:0] OP_SQ    = 5'd7;
  localparam logic [OP_W-1:0] OP_CUBE  = 5'd8;
  localparam logic [OP_W-1:0] OP_TERMS = 5'd9;
  localparam logic [OP_W-1:0] OP_DSUM  = 5'd10;
  localparam logic [OP_W-1:0] OP_MISS  = 5'd11;
  localparam logic [OP_W-1:0] OP_HOT   = 5'd12;
  localparam logic [OP_W-1:0] OP_FIN   = 5'd13;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd14;
  localparam logic [OP_W-1:0] OP_Q3H   = 5'd15;
  localparam logic [OP_W-1:0] OP_Q3L   = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_start;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic trim_zero;
    logic n_nonpos;
    logic series_zero;
    logic over_limit;
    logic norm_done;
    logic div_busy;
    logic d_nonpos;
  } status_t;

  function automatic logic [15:0] lnt(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41196;
      5'd15:   v = 16'd43345;
      5'd16:   v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ttm_if.sv @@
// Valid/ready channel interfaces for samples and temperature results.
interface ttm_in_if;
  import ttm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ttm_out_if;
  import ttm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic                     no_sensor;
  modport source (output valid, output temp_centi, output no_sensor, input ready);
  modport sink (input valid, input temp_centi, input no_sensor, output ready);
endinterface

@@ rtl/thermistor_trimmed_mean_temperature.sv @@
// Top level of the thermistor temperature block: controller, datapath and channel ports.
// Samples are taken one per cycle while a group is being collected. After the last sample
// of a group the input stalls for the conversion, set mostly by the one-bit-per-cycle
// reciprocal division of DIV_W = 54 bits and the one-bit-per-cycle logarithm
// normalisation of up to PW - 1 shifts (PW = 20 + bits of ADC_MAX*(SAMPLES-2)). A group
// that ends early in a missing or hot sensor case goes from the check state straight to
// the output load. The result then sits in an output register, so a new group is
// collected while the previous transaction waits to be taken; a finished conversion
// holds the input off only while that register is still full.
module thermistor_trimmed_mean_temperature import ttm_pkg::*; #(
  parameter int SAMPLES = 12,
  parameter int ADC_MAX = 1023
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ttm_in_if.sink                in_ch,
  ttm_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  ttm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttm_datapath #(
    .SAMPLES (SAMPLES),
    .ADC_MAX (ADC_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (in_ch.sample),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .temp_centi_o (out_ch.temp_centi),
    .no_sensor_o  (out_ch.no_sensor)
  );

  a_no_input_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !in_ch.ready)
    else $error("input accepted while the divider is busy");

  a_missing_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.no_sensor) |-> (out_ch.temp_centi == TEMP_MISSING))
    else $error("missing sensor result with wrong temperature");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.no_sensor) |->
      (out_ch.temp_centi >= TEMP_MIN && out_ch.temp_centi <= TEMP_MAX))
    else $error("temperature outside the saturation range");

endmodule

@@ rtl/ttm_divider.sv @@
// Restoring divider producing one quotient bit per cycle.
module ttm_divider import ttm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W:0]    rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    trial;
  logic              ge;

  assign trial = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/ttm_datapath.sv @@
// Sample accumulation, configuration registers and fixed-point conversion datapath.
module ttm_datapath import ttm_pkg::*; #(
  parameter int SAMPLES = 12,
  parameter int ADC_MAX = 1023
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic signed [TEMP_W-1:0] temp_centi_o,
  output logic                     no_sensor_o
);

  localparam int CNT_W = $clog2(SAMPLES);
  localparam int NMAX  = ADC_MAX * (SAMPLES - 2);
  localparam int NW    = $clog2(NMAX + 1);
  localparam int NSW   = ((NW > SUM_W) ? NW : SUM_W) + 1;
  localparam int PW    = SER_W + NW;
  localparam int EW    = $clog2(PW);
  localparam int PLW   = LIM_W + SUM_W;
  localparam int CMPW  = (PW > PLW) ? PW : PLW;

  logic [SER_W-1:0]         series_q;
  logic [LIM_W-1:0]         limit_q;
  logic signed [CORR_W-1:0] corr_q;

  logic [CNT_W-1:0]    count_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] min_q, max_q;

  logic [SUM_W-1:0]      trimmed_q;
  logic signed [NSW-1:0] n_q;
  logic [PW-1:0]         p_q, px_q;
  logic [PLW-1:0]        plim_q;
  logic [EW-1:0]         ep_q;
  logic [SUM_W-1:0]      tx_q;
  logic [3:0]            et_q;
  logic [LN_W-1:0]       lnp_q, lnt_q;
  logic [LQ_W-1:0]       lqm_q;
  logic                  lqneg_q;
  logic [L2_W-1:0]       l2_q;
  logic [L3_W-1:0]       l3m_q;
  logic [T1_W-1:0]       t1m_q;
  logic [DIV_W-1:0]      t3p_q;
  logic [15:0]           q3h_q;
  logic [4:0]            q3r_q;
  logic [T1_W-1:0]       q3_q;
  logic signed [D_W-1:0] d_q;
  logic signed [TEMP_W-1:0] res_temp_q, out_temp_q;
  logic                     res_miss_q, out_miss_q;

  logic [SUM_W-1:0]      trimmed_d;
  logic signed [NSW-1:0] n_d;
  logic [PW-1:0]         p_d;
  logic [PLW-1:0]        plim_d;
  logic [15:0]           fp, ft;
  logic [15:0]           lkp, lkp1, lkt, lkt1;
  logic [11:0]           dfp, dft;
  logic [23:0]           ipp, ipt;
  logic [21:0]           lnp_d, lnt_d;
  logic signed [LQ_W:0]  lq;
  logic [2*LQ_W-1:0]     sq;
  logic [L2_W+LQ_W-1:0]  cu;
  logic [28+LQ_W-1:0]    t1p;
  logic [22+L3_W:0]      t3p;
  logic [19:0]           zh;
  logic [20:0]           zw;
  logic [42:0]           mh, ml;
  logic [15:0]           qh, ql;
  logic signed [D_W-1:0] t1s, t3s, d_d;
  logic [DIV_W-1:0]      quo;
  logic [DIV_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic                  div_busy;
  logic signed [19:0]    tw;
  logic signed [TEMP_W-1:0] tfin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= SER_W'(47000);
      limit_q  <= LIM_W'(250000);
      corr_q   <= CORR_W'(199);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SERIES: series_q <= cfg_data_i[SER_W-1:0];
        REG_LIMIT:  limit_q  <= cfg_data_i[LIM_W-1:0];
        REG_CORR:   corr_q   <= cfg_data_i[CORR_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else if (cmd_i.op == OP_ACC) begin
      sum_q <= sum_q + SUM_W'(sample_i);
      if (count_q == '0) begin
        min_q <= sample_i;
        max_q <= sample_i;
      end else begin
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
      end
      if (count_q == CNT_W'(SAMPLES - 1)) begin
        count_q <= '0;
      end else begin
        count_q <= count_q + 1'b1;
      end
    end else if (cmd_i.op == OP_TRIM) begin
      sum_q <= '0;
    end
  end

  assign trimmed_d = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
  assign n_d       = NSW'(NMAX) - $signed({{(NSW-SUM_W){1'b0}}, trimmed_d});
  assign p_d       = PW'(series_q) * PW'(n_q[NW-1:0]);
  assign plim_d    = PLW'(limit_q) * PLW'(trimmed_q);

  assign fp   = px_q[PW-2 -: 16];
  assign ft   = {tx_q[SUM_W-2:0], 1'b0};
  assign lkp  = lnt({1'b0, fp[15:12]});
  assign lkp1 = lnt(5'({1'b0, fp[15:12]}) + 5'd1);
  assign lkt  = lnt({1'b0, ft[15:12]});
  assign lkt1 = lnt(5'({1'b0, ft[15:12]}) + 5'd1);
  assign dfp  = 12'(lkp1 - lkp);
  assign dft  = 12'(lkt1 - lkt);
  assign ipp  = 24'(dfp) * 24'(fp[11:0]);
  assign ipt  = 24'(dft) * 24'(ft[11:0]);
  assign lnp_d = 22'(ep_q) * 22'(LN2_Q16) + 22'(lkp) + 22'(ipp[23:12]);
  assign lnt_d = 22'(et_q) * 22'(LN2_Q16) + 22'(lkt) + 22'(ipt[23:12]);

  assign lq  = $signed({1'b0, lnp_q}) - $signed({1'b0, lnt_q});
  assign sq  = (2*LQ_W)'(lqm_q) * (2*LQ_W)'(lqm_q);
  assign cu  = (L2_W+LQ_W)'(l2_q) * (L2_W+LQ_W)'(lqm_q);
  assign t1p = (28+LQ_W)'(COEF_B) * (28+LQ_W)'(lqm_q);
  assign t3p = (23+L3_W)'(COEF_C) * (23+L3_W)'(l3m_q);

  // The cubic term is divided by 6553600 as a shift by 18 and a division by 25, done
  // on the upper bits and then on the remainder joined with the lower 16 bits.
  assign zh = t3p_q[DIV_W-1:34];
  assign mh = 43'(zh) * 43'(RCP25);
  assign qh = mh[RCP_SH+15:RCP_SH];
  assign zw = {q3r_q, t3p_q[33:18]};
  assign ml = 43'(zw) * 43'(RCP25);
  assign ql = ml[RCP_SH+15:RCP_SH];

  assign t1s = lqneg_q ? -$signed({3'b0, t1m_q}) : $signed({3'b0, t1m_q});
  assign t3s = lqneg_q ? -$signed({3'b0, q3_q}) : $signed({3'b0, q3_q});
  assign d_d = $signed(D_W'(COEF_A)) + t1s - t3s;

  assign tw = $signed({3'b0, quo[16:0]}) - KELVIN_OFS
            - $signed({{(20-CORR_W){corr_q[CORR_W-1]}}, corr_q});
  always_comb begin
    if (|quo[DIV_W-1:17]) begin
      tfin = TEMP_MAX;
    end else if (tw > 20'(TEMP_MAX)) begin
      tfin = TEMP_MAX;
    end else if (tw < 20'(TEMP_MIN)) begin
      tfin = TEMP_MIN;
    end else begin
      tfin = tw[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TRIM: begin
        trimmed_q <= trimmed_d;
        n_q       <= n_d;
      end
      OP_MUL: begin
        p_q    <= p_d;
        px_q   <= p_d;
        plim_q <= plim_d;
        ep_q   <= EW'(PW - 1);
        tx_q   <= trimmed_q;
        et_q   <= 4'(SUM_W - 1);
      end
      OP_NORM: begin
        if (!px_q[PW-1]) begin
          px_q <= {px_q[PW-2:0], 1'b0};
          ep_q <= ep_q - 1'b1;
        end
        if (!tx_q[SUM_W-1]) begin
          tx_q <= {tx_q[SUM_W-2:0], 1'b0};
          et_q <= et_q - 1'b1;
        end
      end
      OP_LN: begin
        lnp_q <= lnp_d[LN_W-1:0];
        lnt_q <= lnt_d[LN_W-1:0];
      end
      OP_LQ: begin
        lqneg_q <= lq[LQ_W];
        lqm_q   <= lq[LQ_W] ? LQ_W'(-lq) : lq[LQ_W-1:0];
      end
      OP_SQ:    l2_q  <= sq[2*LQ_W-1:16];
      OP_CUBE:  l3m_q <= cu[L2_W+LQ_W-1:16];
      OP_TERMS: begin
        t1m_q <= t1p[28+LQ_W-1:16];
        t3p_q <= DIV_W'(t3p);
      end
      OP_Q3H: begin
        q3h_q <= qh;
        q3r_q <= 5'(zh - 20'(qh) * 20'(DIV25));
      end
      OP_Q3L:   q3_q <= T1_W'({q3h_q, ql});
      OP_DSUM:  d_q <= d_d;
      OP_MISS: begin
        res_temp_q <= TEMP_MISSING;
        res_miss_q <= 1'b1;
      end
      OP_HOT: begin
        res_temp_q <= TEMP_MAX;
        res_miss_q <= 1'b0;
      end
      OP_FIN: begin
        res_temp_q <= tfin;
        res_miss_q <= 1'b0;
      end
      OP_LOAD: begin
        out_temp_q <= res_temp_q;
        out_miss_q <= res_miss_q;
      end
      default: ;
    endcase
  end

  assign div_dividend = ONE_E14 + DIV_W'(d_q[D_W-1:1]);
  assign div_divisor  = d_q[DVS_W-1:0];

  ttm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign status_o.last        = count_q == CNT_W'(SAMPLES - 1);
  assign status_o.trim_zero   = trimmed_q == '0;
  assign status_o.n_nonpos    = n_q[NSW-1] || (n_q == '0);
  assign status_o.series_zero = series_q == '0;
  assign status_o.over_limit  = CMPW'(p_q) > CMPW'(plim_q);
  assign status_o.norm_done   = px_q[PW-1] & tx_q[SUM_W-1];
  assign status_o.div_busy    = div_busy;
  assign status_o.d_nonpos    = d_q[D_W-1] || (d_q == '0);

  assign temp_centi_o = out_temp_q;
  assign no_sensor_o  = out_miss_q;

endmodule

@@ rtl/ttm_ctrl.sv @@
// Controller state machine sequencing accumulation, conversion and result hand-off.
module ttm_ctrl import ttm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_TRIM  = 5'd1;
  localparam logic [ST_W-1:0] S_MUL   = 5'd2;
  localparam logic [ST_W-1:0] S_CHK   = 5'd3;
  localparam logic [ST_W-1:0] S_NORM  = 5'd4;
  localparam logic [ST_W-1:0] S_LN    = 5'd5;
  localparam logic [ST_W-1:0] S_LQ    = 5'd6;
  localparam logic [ST_W-1:0] S_SQ    = 5'd7;
  localparam logic [ST_W-1:0] S_CUBE  = 5'd8;
  localparam logic [ST_W-1:0] S_TERMS = 5'd9;
  localparam logic [ST_W-1:0] S_Q3H   = 5'd10;
  localparam logic [ST_W-1:0] S_Q3L   = 5'd11;
  localparam logic [ST_W-1:0] S_DSUM  = 5'd12;
  localparam logic [ST_W-1:0] S_DCHK  = 5'd13;
  localparam logic [ST_W-1:0] S_DIVTW = 5'd14;
  localparam logic [ST_W-1:0] S_FIN   = 5'd15;
  localparam logic [ST_W-1:0] S_LOAD  = 5'd16;

  logic [ST_W-1:0] state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op        = OP_NONE;
    cmd_o.div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_ACC;
          if (status_i.last) state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        cmd_o.op = OP_TRIM;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (status_i.trim_zero) begin
          cmd_o.op = OP_MISS;
          state_d  = S_LOAD;
        end else if (status_i.n_nonpos || status_i.series_zero) begin
          cmd_o.op = OP_HOT;
          state_d  = S_LOAD;
        end else if (status_i.over_limit) begin
          cmd_o.op = OP_MISS;
          state_d  = S_LOAD;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          state_d = S_LN;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      S_LN: begin
        cmd_o.op = OP_LN;
        state_d  = S_LQ;
      end
      S_LQ: begin
        cmd_o.op = OP_LQ;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.op = OP_CUBE;
        state_d  = S_TERMS;
      end
      S_TERMS: begin
        cmd_o.op = OP_TERMS;
        state_d  = S_Q3H;
      end
      S_Q3H: begin
        cmd_o.op = OP_Q3H;
        state_d  = S_Q3L;
      end
      S_Q3L: begin
        cmd_o.op = OP_Q3L;
        state_d  = S_DSUM;
      end
      S_DSUM: begin
        cmd_o.op = OP_DSUM;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        if (status_i.d_nonpos) begin
          cmd_o.op = OP_HOT;
          state_d  = S_LOAD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVTW;
        end
      end
      S_DIVTW: begin
        if (!status_i.div_busy) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ test/tb_thermistor_trimmed_mean_temperature.sv @@
// Self-checking testbench of the thermistor temperature block: directed table, then random groups.
module tb_thermistor_trimmed_mean_temperature;
  import ttm_pkg::*;

  localparam int NSAMP = 12;
  localparam int ADCMX = 1023;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     missing;
  } reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0]      sample;
    bit                       known;
    logic signed [TEMP_W-1:0] temp;
    logic                     missing;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_SERIES;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ttm_in_if in_ch ();
  ttm_out_if out_ch ();

  thermistor_trimmed_mean_temperature dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #8000000;
    $display("tb_thermistor_trimmed_mean_temperature: errors");
    $finish;
  end

  logic [63:0] series_r = 47000;
  logic [63:0] limit_r = 250000;
  longint      corr_r = 199;
  int          grp_count;
  int          grp_sum;
  int          grp_lo;
  int          grp_hi;

  reading_t pending_readings[$];
  int errors = 0;
  int results_seen = 0;
  int missing_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic longint ln_fixed(longint unsigned x);
    longint lnt_v[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                          29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
    int e;
    longint unsigned f;
    int k;
    longint r;
    if (x == 0) return 0;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= 16) f = (x >> (e - 16)) & 64'hFFFF;
    else f = (x << (16 - e)) & 64'hFFFF;
    k = int'(f >> 12);
    r = longint'(f & 64'hFFF);
    return e * lnt_v[16] + lnt_v[k] + ((lnt_v[k + 1] - lnt_v[k]) * r) / 4096;
  endfunction

  function automatic reading_t temperature_of(longint trimmed);
    reading_t res;
    longint n, lq, l2, l3, d, t;
    longint unsigned p;
    res.missing = 1'b0;
    n = longint'(ADCMX) * (NSAMP - 2) - trimmed;
    if (trimmed == 0) begin
      res.missing = 1'b1;
      res.temp = TEMP_MISSING;
      return res;
    end
    if (n <= 0 || series_r == 0) begin
      res.temp = TEMP_MAX;
      return res;
    end
    p = series_r * longint'(n);
    if (p > limit_r * trimmed) begin
      res.missing = 1'b1;
      res.temp = TEMP_MISSING;
      return res;
    end
    lq = ln_fixed(p) - ln_fixed(trimmed);
    l2 = (lq * lq) / 65536;
    l3 = (l2 * lq) / 65536;
    d = 416822000 + (262234000 * lq) / 65536 - (6726371 * l3) / 6553600;
    if (d <= 0) begin
      res.temp = TEMP_MAX;
      return res;
    end
    t = (64'd100000000000000 + d / 2) / d;
    t = t - 27315 - corr_r;
    if (t < -10000) t = -10000;
    if (t > 30000) t = 30000;
    res.temp = TEMP_W'(t);
    return res;
  endfunction

  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s, output bit done,
                                   output reading_t res);
    int v;
    v = s;
    if (grp_count == 0) begin
      grp_lo = v;
      grp_hi = v;
    end else begin
      if (v < grp_lo) grp_lo = v;
      if (v > grp_hi) grp_hi = v;
    end
    grp_sum = (grp_sum + v) & 16'hFFFF;
    done = 1'b0;
    if (grp_count + 1 < NSAMP) begin
      grp_count++;
      return;
    end
    res = temperature_of(longint'(grp_sum) - grp_lo - grp_hi);
    grp_count = 0;
    grp_sum = 0;
    done = 1'b1;
  endtask

  // Receiver side: stalls at random or for a long hold, checks each transaction.
  initial begin
    reading_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready && rst_ni) begin
        results_seen++;
        if (out_ch.no_sensor) missing_seen++;
        if (pending_readings.size() == 0) begin
          $error("unexpected transaction: temp_centi %0d", out_ch.temp_centi);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          if (out_ch.temp_centi !== want.temp) begin
            $error("temp_centi: expected %0d, got %0d", want.temp, out_ch.temp_centi);
            errors++;
          end
          if (out_ch.no_sensor !== want.missing) begin
            $error("no_sensor: expected %0d, got %0d", want.missing, out_ch.no_sensor);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_SERIES) series_r = val & 22'hFFFFF;
    else if (idx == REG_LIMIT) limit_r = val;
    else if (idx == REG_CORR) corr_r = $signed(val[CORR_W-1:0]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit known,
                             input reading_t fixed);
    bit done;
    reading_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    accumulate_sample(s, done, res);
    if (done) pending_readings.push_back(known ? fixed : res);
  endtask

  task automatic send_group(input int kind);
    int base, spread;
    reading_t none;
    base = $urandom_range(1023);
    spread = $urandom_range(1) ? 3 : 1023;
    for (int i = 0; i < NSAMP; i++) begin
      case (kind)
        0: send_sample(10'($urandom_range(1023)), 1'b0, none);
        1: send_sample(10'(base + $urandom_range(spread) - spread / 2), 1'b0, none);
        default: send_sample($urandom_range(1) ? 10'd0 : 10'd1023, 1'b0, none);
      endcase
    end
  endtask

  initial begin
    row_t rows[$];
    reading_t none;
    int phase;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    grp_count = 0;
    grp_sum = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All zero: trimmed sum is zero, so the sensor reads as missing.
    for (int i = 0; i < NSAMP; i++)
      rows.push_back('{10'd0, i == NSAMP - 1, TEMP_MISSING, 1'b1});
    // All full scale: no resistance left, reads as hot.
    for (int i = 0; i < NSAMP; i++)
      rows.push_back('{10'd1023, i == NSAMP - 1, TEMP_MAX, 1'b0});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, '{rows[i].temp, rows[i].missing});
    for (int i = 0; i < NSAMP; i++) send_sample(10'(512 + i), 1'b0, none);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_SERIES, 22'd1000); write_reg(REG_LIMIT, 22'd4000000);
                 write_reg(REG_CORR, 22'(-1000) & 22'h7FF); end
        1: begin write_reg(REG_SERIES, 22'd1000000); write_reg(REG_LIMIT, 22'd1000);
                 write_reg(REG_CORR, 22'd1000); end
        2: begin write_reg(REG_SERIES, 22'd10000); write_reg(REG_LIMIT, 22'd4000000);
                 write_reg(REG_CORR, 22'd0); write_reg(2'd3, 22'h3FFFFF); end
        3: begin write_reg(REG_SERIES, 22'hFFFFF); write_reg(REG_LIMIT, 22'h3FFFFF);
                 write_reg(REG_CORR, 22'h400); end
        4: begin write_reg(REG_SERIES, 22'd0); end
        default: begin write_reg(REG_SERIES, 22'd47000); write_reg(REG_LIMIT, 22'd250000);
                 write_reg(REG_CORR, 22'd199); end
      endcase
      cfg_we_i <= 1'b0;
      send_idle_pct = 0; recv_stall_pct = 0;
      if (phase == 1) send_idle_pct = 81;
      if (phase == 2) recv_stall_pct = 81;
      if (phase == 3) begin send_idle_pct = 21; recv_stall_pct = 21; end
      if (phase == 5) hold_cycles = 1500;
      for (int g = 0; g < 11; g++) begin
        send_group(g % 5 == 4 ? 0 : (g % 7 == 6 ? 2 : 1));
        if (phase == 5 && g == 5) begin
          in_ch.valid <= 1'b0;
          while (pending_readings.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Covered %0d results (%0d sensor-missing) over six register settings,",
             results_seen, missing_seen);
    $display("with sender gaps, receiver stalls and a long output hold.");
    if (errors == 0) begin
      $display("tb_thermistor_trimmed_mean_temperature: clean");
    end else begin
      $display("tb_thermistor_trimmed_mean_temperature: errors");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/ttm_pkg.sv
rtl/ttm_if.sv
rtl/ttm_divider.sv
rtl/ttm_datapath.sv
rtl/ttm_ctrl.sv
rtl/thermistor_trimmed_mean_temperature.sv
test/tb_thermistor_trimmed_mean_temperature.sv
